@@ rtl/spdl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spdl_pkg
// Shared types, sizes and codes for the smoothed pointer delay line.
// ----------------------------------------------------------------------------
package spdl_pkg;

    localparam int SAMPLE_RATE = 128;
    localparam int QUEUE_DEPTH = 1024;

    localparam int PIX_W    = 12;
    localparam int FRAC_W   = 8;
    localparam int COORD_W  = PIX_W + FRAC_W;
    localparam int FPS_W    = 8;
    localparam int DEPTH_W  = 10;
    localparam int ALPHA_W  = 17;
    localparam int ADDR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int N_W      = $clog2(SAMPLE_RATE) + 1;
    localparam int DIVD_W   = COORD_W + N_W;
    localparam int DIVS_W   = FPS_W + 1;
    localparam int EMA_W    = COORD_W + ALPHA_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = ALPHA_W;

    localparam logic [ALPHA_W-1:0] Q_ONE = ALPHA_W'(65536);
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(128);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_DEPTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA   = 1'b1;

    localparam logic OP_PRESS = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } pt_t;

    typedef struct packed {
        logic               op;
        logic [PIX_W-1:0]   pos_x;
        logic [PIX_W-1:0]   pos_y;
        logic [FPS_W-1:0]   fps_average;
        logic               cursor_active;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] shadow_x;
        logic [COORD_W-1:0] shadow_y;
        logic               shadow_moved;
        logic               handled;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic press;
        logic n_start;
        logic n_load;
        logic lmul;
        logic ldiv_start;
        logic lerp_load;
        logic ema_mul;
        logic ema_sum;
        logic push;
        logic full_wr;
        logic pop;
        logic pop_rd;
        logic pop_cap;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic active;
        logic div_done;
        logic q_zero;
        logic count_nz;
        logic count_full;
        logic last_i;
        logic need_pop;
    } stat_t;

endpackage
`default_nettype wire

@@ rtl/spdl_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spdl_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module spdl_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/spdl_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spdl_div
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module spdl_div import spdl_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] divd_x,
    input  wire logic [DIVD_W-1:0] divd_y,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   done,
    output logic      [DIVD_W-1:0] quo_x,
    output logic      [DIVD_W-1:0] quo_y
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DIVD_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [DIVS_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [DIVS_W-1:0] d_reg, d_next;
    logic [DIVS_W:0]   tx, ty;

    always_comb begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        qx_next   = qx_reg;
        qy_next   = qy_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        d_next    = d_reg;
        tx        = {rx_reg, qx_reg[DIVD_W-1]};
        ty        = {ry_reg, qy_reg[DIVD_W-1]};
        if (start) begin
            cnt_next = STEP_W'(DIVD_W);
            qx_next  = divd_x;
            qy_next  = divd_y;
            rx_next  = '0;
            ry_next  = '0;
            d_next   = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - STEP_W'(1);
            done_next = (cnt_reg == STEP_W'(1));
            if (tx >= {1'b0, d_reg}) begin
                rx_next = DIVS_W'(tx - {1'b0, d_reg});
                qx_next = {qx_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rx_next = tx[DIVS_W-1:0];
                qx_next = {qx_reg[DIVD_W-2:0], 1'b0};
            end
            if (ty >= {1'b0, d_reg}) begin
                ry_next = DIVS_W'(ty - {1'b0, d_reg});
                qy_next = {qy_reg[DIVD_W-2:0], 1'b1};
            end else begin
                ry_next = ty[DIVS_W-1:0];
                qy_next = {qy_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        qx_reg <= qx_next;
        qy_reg <= qy_next;
        rx_reg <= rx_next;
        ry_reg <= ry_next;
        d_reg  <= d_next;
    end

    assign done  = done_reg;
    assign quo_x = qx_reg;
    assign quo_y = qy_reg;

endmodule
`default_nettype wire

@@ rtl/spdl_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spdl_dp
// Datapath: queue RAM, pointers, interpolation, smoothing and output register.
// ----------------------------------------------------------------------------
module spdl_dp import spdl_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output stat_t                     st,
    input  wire in_item_t             s_data,
    output out_item_t                 m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    in_item_t           in_reg;
    pt_t                press_reg, last_reg, start_reg, pt_reg, popped_reg, shadow_reg;
    logic               moved_reg, handled_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [N_W-1:0]     n_reg, i_reg;
    logic [DIVD_W-1:0]  mx0_reg, mx1_reg, my0_reg, my1_reg;
    logic [EMA_W-1:0]   ex0_reg, ex1_reg, ey0_reg, ey1_reg;
    out_item_t          out_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    logic [FPS_W-1:0]   fps_eff;
    logic [ALPHA_W-1:0] a_sat, a_inv;
    logic [COORD_W-1:0] cur_x, cur_y;
    logic [CNT_W-1:0]   depth_ext;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  divd_x, divd_y, quo_x, quo_y;
    logic [DIVS_W-1:0]  divisor;
    logic [EMA_W:0]     esum_x, esum_y;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    pt_t                ram_rdata, pt_ema, out_pt;

    assign fps_eff   = (in_reg.fps_average == '0) ? FPS_W'(1) : in_reg.fps_average;
    assign a_sat     = (alpha_reg > Q_ONE) ? Q_ONE : alpha_reg;
    assign a_inv     = Q_ONE - a_sat;
    assign cur_x     = {in_reg.pos_x, FRAC_W'(0)};
    assign cur_y     = {in_reg.pos_y, FRAC_W'(0)};
    assign depth_ext = CNT_W'(depth_reg);

    always_comb begin
        div_start = cmd.n_start | cmd.ldiv_start;
        if (cmd.n_start) begin
            divd_x  = DIVD_W'(2 * SAMPLE_RATE) + DIVD_W'(fps_eff);
            divd_y  = '0;
            divisor = {fps_eff, 1'b0};
        end else begin
            divd_x  = mx0_reg + mx1_reg + DIVD_W'(n_reg >> 1);
            divd_y  = my0_reg + my1_reg + DIVD_W'(n_reg >> 1);
            divisor = DIVS_W'(n_reg);
        end
    end

    spdl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divd_x  (divd_x),
        .divd_y  (divd_y),
        .divisor (divisor),
        .done    (div_done),
        .quo_x   (quo_x),
        .quo_y   (quo_y)
    );

    assign ram_we    = (cmd.push & ~st.count_full) | cmd.full_wr;
    assign ram_waddr = head_reg + count_reg[ADDR_W-1:0];
    assign ram_raddr = cmd.pop_rd ? (head_reg - ADDR_W'(1)) : head_reg;

    spdl_ram #(
        .WIDTH ($bits(pt_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pt_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign esum_x   = {1'b0, ex0_reg} + {1'b0, ex1_reg} + (EMA_W + 1)'(32768);
    assign esum_y   = {1'b0, ey0_reg} + {1'b0, ey1_reg} + (EMA_W + 1)'(32768);
    assign pt_ema.x = esum_x[16 +: COORD_W];
    assign pt_ema.y = esum_y[16 +: COORD_W];
    assign out_pt   = moved_reg ? popped_reg : shadow_reg;

    always_comb begin
        st.op         = in_reg.op;
        st.active     = in_reg.cursor_active;
        st.div_done   = div_done;
        st.q_zero     = (quo_x[N_W-1:0] == '0);
        st.count_nz   = (count_reg != '0);
        st.count_full = (count_reg == CNT_W'(QUEUE_DEPTH));
        st.last_i     = (i_reg == n_reg);
        st.need_pop   = (count_reg > depth_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_reg  <= '0;
            shadow_reg <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            depth_reg  <= DEPTH_RESET;
            alpha_reg  <= ALPHA_RESET;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DELAY_DEPTH: depth_reg <= cfg_wdata[DEPTH_W-1:0];
                    CFG_EMA_ALPHA:   alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.press) begin
                press_reg.x <= cur_x;
                press_reg.y <= cur_y;
                count_reg   <= '0;
            end
            if (cmd.push && !st.count_full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            // full queue: pop oldest and push in the same slot, count holds
            if (cmd.full_wr) begin
                head_reg <= head_reg + ADDR_W'(1);
            end
            if (cmd.pop) begin
                head_reg  <= head_reg + ADDR_W'(count_reg - depth_ext);
                count_reg <= depth_ext;
            end
            if (cmd.fin) begin
                shadow_reg <= out_pt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg      <= s_data;
            moved_reg   <= 1'b0;
            handled_reg <= 1'b0;
        end
        if (cmd.n_load) begin
            n_reg       <= quo_x[N_W-1:0];
            i_reg       <= N_W'(1);
            start_reg   <= st.count_nz ? last_reg : press_reg;
            handled_reg <= 1'b1;
        end
        if (cmd.lmul) begin
            mx0_reg <= DIVD_W'(start_reg.x) * DIVD_W'(n_reg - i_reg);
            mx1_reg <= DIVD_W'(cur_x) * DIVD_W'(i_reg);
            my0_reg <= DIVD_W'(start_reg.y) * DIVD_W'(n_reg - i_reg);
            my1_reg <= DIVD_W'(cur_y) * DIVD_W'(i_reg);
        end
        if (cmd.lerp_load) begin
            pt_reg.x <= quo_x[COORD_W-1:0];
            pt_reg.y <= quo_y[COORD_W-1:0];
        end
        if (cmd.ema_mul) begin
            ex0_reg <= EMA_W'(a_sat) * EMA_W'(pt_reg.x);
            ex1_reg <= EMA_W'(a_inv) * EMA_W'(last_reg.x);
            ey0_reg <= EMA_W'(a_sat) * EMA_W'(pt_reg.y);
            ey1_reg <= EMA_W'(a_inv) * EMA_W'(last_reg.y);
        end
        if (cmd.ema_sum) begin
            pt_reg <= pt_ema;
        end
        if (cmd.push || cmd.full_wr) begin
            last_reg <= pt_reg;
            i_reg    <= i_reg + N_W'(1);
        end
        if (cmd.full_wr) begin
            popped_reg <= ram_rdata;
            moved_reg  <= 1'b1;
        end
        if (cmd.pop) begin
            moved_reg <= 1'b1;
        end
        if (cmd.pop_cap) begin
            popped_reg <= ram_rdata;
        end
        if (cmd.fin) begin
            out_reg.shadow_x     <= out_pt.x;
            out_reg.shadow_y     <= out_pt.y;
            out_reg.shadow_moved <= moved_reg;
            out_reg.handled      <= handled_reg;
        end
    end

    assign m_data = out_reg;

endmodule
`default_nettype wire

@@ rtl/spdl_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spdl_ctrl
// Sequencer for press, tick, per-point interpolation and trimming of the queue.
// ----------------------------------------------------------------------------
module spdl_ctrl import spdl_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_NWAIT  = 4'd2;
    localparam logic [3:0] S_LMUL   = 4'd3;
    localparam logic [3:0] S_LDIV   = 4'd4;
    localparam logic [3:0] S_LWAIT  = 4'd5;
    localparam logic [3:0] S_EMUL   = 4'd6;
    localparam logic [3:0] S_ESUM   = 4'd7;
    localparam logic [3:0] S_PUSH   = 4'd8;
    localparam logic [3:0] S_FULLWR = 4'd9;
    localparam logic [3:0] S_POP    = 4'd10;
    localparam logic [3:0] S_POPRD  = 4'd11;
    localparam logic [3:0] S_POPCAP = 4'd12;
    localparam logic [3:0] S_FIN    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (st.op == OP_PRESS) begin
                    cmd.press  = 1'b1;
                    state_next = S_FIN;
                end else if (st.active) begin
                    cmd.n_start = 1'b1;
                    state_next  = S_NWAIT;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_NWAIT: begin
                if (st.div_done) begin
                    cmd.n_load = 1'b1;
                    state_next = st.q_zero ? S_POP : S_LMUL;
                end
            end
            S_LMUL: begin
                cmd.lmul   = 1'b1;
                state_next = S_LDIV;
            end
            S_LDIV: begin
                cmd.ldiv_start = 1'b1;
                state_next     = S_LWAIT;
            end
            S_LWAIT: begin
                if (st.div_done) begin
                    cmd.lerp_load = 1'b1;
                    state_next    = st.count_nz ? S_EMUL : S_PUSH;
                end
            end
            S_EMUL: begin
                cmd.ema_mul = 1'b1;
                state_next  = S_ESUM;
            end
            S_ESUM: begin
                cmd.ema_sum = 1'b1;
                state_next  = S_PUSH;
            end
            S_PUSH: begin
                // a full queue reads the oldest item first, then overwrites it
                if (st.count_full) begin
                    state_next = S_FULLWR;
                end else begin
                    cmd.push   = 1'b1;
                    state_next = st.last_i ? S_POP : S_LMUL;
                end
            end
            S_FULLWR: begin
                cmd.full_wr = 1'b1;
                state_next  = st.last_i ? S_POP : S_LMUL;
            end
            S_POP: begin
                if (st.need_pop) begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPRD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_POPRD: begin
                cmd.pop_rd = 1'b1;
                state_next = S_POPCAP;
            end
            S_POPCAP: begin
                cmd.pop_cap = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.fin      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DECODE))
        else $error("accepted item did not start processing");

    a_fin_holds_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && m_valid_reg && !m_ready) |=> (state_reg == S_FIN))
        else $error("result finished while output register was occupied");

    a_lerp_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LWAIT && st.div_done) |=>
            (state_reg == S_EMUL || state_reg == S_PUSH))
        else $error("interpolated point not forwarded");

    a_fin_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin |=> m_valid_reg)
        else $error("result loaded without valid");

endmodule
`default_nettype wire

@@ rtl/smoothed_pointer_delay_line_top.sv @@
`default_nettype none
// Throughput: one item at a time, next item taken the cycle after the result
//   is loaded; the 28-step divider used per point sets it.
// Reset: control, pointers, press and shadow points clear; queue RAM undefined.
// ----------------------------------------------------------------------------
// smoothed_pointer_delay_line_top
// Delayed, smoothed shadow of a pointer fed by press events and frame ticks.
// ----------------------------------------------------------------------------
module smoothed_pointer_delay_line_top import spdl_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_item_t             s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_item_t                 m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    cmd_t  cmd;
    stat_t st;

    spdl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    spdl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule
`default_nettype wire

@@ tb/tb_smoothed_pointer_delay_line_top.sv @@
// ----------------------------------------------------------------------------
// tb_smoothed_pointer_delay_line_top
// Drives press events and frame ticks through the delay line, predicts each
// shadow point and its flags in step with the block, and checks every result.
// ----------------------------------------------------------------------------
module tb_smoothed_pointer_delay_line_top;
    import spdl_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    smoothed_pointer_delay_line_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    localparam int CYCLE_LIMIT = 40000000;

    // predictor state
    pt_t              hist_q [QUEUE_DEPTH];
    int unsigned      hist_count;
    int unsigned      hist_head;
    pt_t              press_pt;
    pt_t              shadow_pt;
    int unsigned      depth_reg;
    int unsigned      alpha_reg;

    in_item_t         pending_items[$];
    out_item_t        shadow_expected[$];
    int               errors;
    int               cycles;
    bit               quiet;
    bit               drive_en;

    function automatic logic [COORD_W-1:0] lerp(int unsigned a, int unsigned b,
                                                int unsigned i, int unsigned n);
        longint unsigned s;
        s = longint'(a) * (n - i) + longint'(b) * i + n / 2;
        return COORD_W'(s / n);
    endfunction

    function automatic logic [COORD_W-1:0] smooth(int unsigned nw, int unsigned last,
                                                  int unsigned a);
        longint unsigned s;
        s = longint'(a) * nw + longint'(65536 - a) * last + 32768;
        return COORD_W'(s >> 16);
    endfunction

    function automatic pt_t pop_hist();
        pt_t v;
        v = hist_q[hist_head];
        hist_head = (hist_head + 1) % QUEUE_DEPTH;
        hist_count--;
        return v;
    endfunction

    task automatic add_item(input in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic predict_shadow(input in_item_t it);
        out_item_t   r;
        int unsigned a, fps, n;
        pt_t         start, last, popped, p;
        bit          moved;
        moved = 1'b0;
        r = '0;
        if (it.op == OP_PRESS) begin
            press_pt.x = {it.pos_x, 8'd0};
            press_pt.y = {it.pos_y, 8'd0};
            hist_count = 0;
        end else if (it.cursor_active) begin
            r.handled = 1'b1;
            a = alpha_reg > 65536 ? 65536 : alpha_reg;
            fps = it.fps_average == 0 ? 1 : it.fps_average;
            n = (2 * SAMPLE_RATE + fps) / (2 * fps);
            start = hist_count ? hist_q[(hist_head + hist_count - 1) % QUEUE_DEPTH]
                               : press_pt;
            popped = '0;
            for (int unsigned i = 1; i <= n; i++) begin
                p.x = lerp(start.x, {it.pos_x, 8'd0}, i, n);
                p.y = lerp(start.y, {it.pos_y, 8'd0}, i, n);
                if (hist_count != 0) begin
                    last = hist_q[(hist_head + hist_count - 1) % QUEUE_DEPTH];
                    p.x = smooth(p.x, last.x, a);
                    p.y = smooth(p.y, last.y, a);
                end
                if (hist_count >= QUEUE_DEPTH) begin
                    popped = pop_hist();
                    moved = 1'b1;
                end
                hist_q[(hist_head + hist_count) % QUEUE_DEPTH] = p;
                hist_count++;
            end
            while (hist_count > depth_reg) begin
                popped = pop_hist();
                moved = 1'b1;
            end
            if (moved) shadow_pt = popped;
        end
        r.shadow_x = shadow_pt.x;
        r.shadow_y = shadow_pt.y;
        r.shadow_moved = moved;
        shadow_expected.insert(shadow_expected.size(), r);
    endtask

    function automatic in_item_t make_item(bit op, int unsigned x, int unsigned y,
                                           int unsigned fps, int unsigned act);
        in_item_t it;
        it.op = op;
        it.pos_x = PIX_W'(x);
        it.pos_y = PIX_W'(y);
        it.fps_average = FPS_W'(fps);
        it.cursor_active = act[0];
        return it;
    endfunction

    function automatic in_item_t rand_item();
        int unsigned fps, r;
        r = $urandom_range(0, 99);
        // mostly active ticks, fps weighted toward fast frames (few points)
        if (r < 8)
            return make_item(OP_PRESS, $urandom, $urandom, $urandom, $urandom);
        if (r < 14)
            return make_item(OP_TICK, $urandom, $urandom, $urandom, 0);
        r = $urandom_range(0, 99);
        if (r < 70) fps = $urandom_range(16, 255);
        else if (r < 95) fps = $urandom_range(2, 15);
        else fps = $urandom_range(0, 1);
        return make_item(OP_TICK, $urandom, $urandom, fps, 1);
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn && !(s_valid && !s_ready)) begin
            if (s_valid && s_ready) predict_shadow(s_data);
            if (drive_en && pending_items.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= 28)) begin
                s_data <= pending_items[0];
                pending_items.delete(0);
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (shadow_expected.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    e = shadow_expected[0];
                    shadow_expected.delete(0);
                    if (m_data.shadow_x !== e.shadow_x) begin
                        $display("%0t: shadow_x exp %h got %h", $time, e.shadow_x,
                                 m_data.shadow_x);
                        errors++;
                    end
                    if (m_data.shadow_y !== e.shadow_y) begin
                        $display("%0t: shadow_y exp %h got %h", $time, e.shadow_y,
                                 m_data.shadow_y);
                        errors++;
                    end
                    if (m_data.shadow_moved !== e.shadow_moved) begin
                        $display("%0t: shadow_moved exp %b got %b", $time,
                                 e.shadow_moved, m_data.shadow_moved);
                        errors++;
                    end
                    if (m_data.handled !== e.handled) begin
                        $display("%0t: handled exp %b got %b", $time, e.handled,
                                 m_data.handled);
                        errors++;
                    end
                end
            end
            m_ready <= quiet || $urandom_range(0, 99) >= 28;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_DELAY_DEPTH) depth_reg = val & 10'h3FF;
        else alpha_reg = val & 17'h1FFFF;
    endtask

    // hand a batch to the driver and wait until every result is back
    task automatic run_batch();
        drive_en = 1'b1;
        wait (pending_items.size() == 0 && !s_valid);
        wait (shadow_expected.size() == 0);
        drive_en = 1'b0;
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int unsigned depths[6];
        int unsigned alphas[6];
        depths = '{128, 1, 0, 1023, 896, 5};
        alphas = '{32768, 65536, 1, 0, 131071, 20000};
        aresetn = 0; s_valid = 0; s_data = '0; m_ready = 0;
        cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
        errors = 0; cycles = 0; quiet = 0; drive_en = 0;
        hist_count = 0; hist_head = 0; press_pt = '0; shadow_pt = '0;
        depth_reg = 128; alpha_reg = 32768;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, inactive tick, zero fps, press resets the queue
        add_item(make_item(OP_TICK, 100, 200, 60, 1));
        add_item(make_item(OP_PRESS, 4095, 0, 255, 1));
        add_item(make_item(OP_TICK, 0, 4095, 0, 1));
        add_item(make_item(OP_TICK, 4095, 4095, 1, 1));
        add_item(make_item(OP_TICK, 123, 456, 30, 0));
        add_item(make_item(OP_TICK, 0, 0, 255, 1));
        add_item(make_item(OP_TICK, 2048, 1024, 171, 1));
        add_item(make_item(OP_PRESS, 0, 4095, 0, 0));
        add_item(make_item(OP_TICK, 4095, 0, 128, 1));
        add_item(make_item(OP_TICK, 1, 2, 2, 1));
        run_batch();

        // full queue: depth 1023 with many ticks at fps 1 overflows 1024
        write_reg(CFG_DELAY_DEPTH, 1023);
        for (int k = 0; k < 12; k++)
            add_item(make_item(OP_TICK, $urandom, $urandom, 1, 1));
        run_batch();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_DELAY_DEPTH, depths[ph]);
            write_reg(CFG_EMA_ALPHA, alphas[ph]);
            quiet = (ph == 3);
            for (int k = 0; k < 240; k++) add_item(rand_item());
            run_batch();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
